// ===== rtl/ppc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pool pump controller package
// Shared types, register indexes and status codes for the pump, UV lamp and
// heater controller.
// ----------------------------------------------------------------------------
package ppc_pkg;

	typedef enum logic [1:0] {
		MODE_STOP       = 2'd0,
		MODE_FILTER     = 2'd1,
		MODE_SCHEDULED  = 2'd2,
		MODE_HEAT       = 2'd3
	} mode_t;

	localparam logic CMD_EVALUATE = 1'b0;
	localparam logic CMD_TICK     = 1'b1;

	localparam logic [1:0] DEV_OFF        = 2'd0;
	localparam logic [1:0] DEV_ON         = 2'd1;
	localparam logic [1:0] DEV_LOW_FLOW   = 2'd2;

	localparam logic [2:0] REG_MODE          = 3'd0;
	localparam logic [2:0] REG_SETPOINT      = 3'd1;
	localparam logic [2:0] REG_HYSTERESIS    = 3'd2;
	localparam logic [2:0] REG_FLOW_THRESH   = 3'd3;
	localparam logic [2:0] REG_HOUR_MASK     = 3'd4;
	localparam logic [2:0] REG_STARTUP_SPEED = 3'd5;
	localparam logic [2:0] REG_STARTUP_TICKS = 3'd6;

	localparam int CFG_DATA_W  = 24;
	localparam int CFG_INDEX_W = 3;
	localparam int HOURS       = 24;

	localparam logic [5:0]  SETPOINT_RST      = 6'd20;
	localparam logic [7:0]  HYSTERESIS_RST    = 8'd5;
	localparam logic [15:0] FLOW_THRESH_RST   = 16'd1;
	localparam logic [23:0] HOUR_MASK_RST     = 24'h551111;
	localparam logic [9:0]  STARTUP_SPEED_RST = 10'd161;
	localparam logic [15:0] STARTUP_TICKS_RST = 16'd4000;

	typedef struct packed {
		logic               command;
		logic        [4:0]  hour;
		logic        [15:0] flow_lph;
		logic signed [11:0] temperature;
		logic        [9:0]  speed_setting;
	} in_item_t;

	typedef struct packed {
		logic       pump_status;
		logic       pump_starting;
		logic       pump_enable;
		logic [7:0] pump_pwm;
		logic [1:0] uv_status;
		logic [1:0] heater_status;
		logic       uv_drive;
		logic       heater_drive;
	} out_item_t;

endpackage
`default_nettype wire

// ===== rtl/pool_pump_heater_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A result is registered into the output register, or into the skid register while the output waits.
// Throughput: one item per cycle while in_stall is low; the device state updates in a single pass.
// An output register plus one skid register keep input transfers going while
// a result waits, until the skid fills; in_stall rises only when the skid is full.
// Reset clears the device state, the output valid flags and loads the
// register defaults (stop mode, setpoint 20, 4000 startup ticks).
// ----------------------------------------------------------------------------
// Pool pump, UV lamp and heater controller
// Mode logic, counted pump startup and a hysteresis thermostat driven by
// evaluate and millisecond tick items.
// ----------------------------------------------------------------------------
module pool_pump_heater_controller (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire [ppc_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  wire [ppc_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  ppc_pkg::in_item_t                    in_data,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output ppc_pkg::out_item_t                   out_data
);

	ppc_pkg::mode_t mode_q;
	logic [5:0]  setpoint_q;
	logic [7:0]  hysteresis_q;
	logic [15:0] flow_thresh_q;
	logic [23:0] hour_mask_q;
	logic [9:0]  startup_speed_q;
	logic [15:0] startup_ticks_q;

	logic        pump_on_q, start_phase_q;
	logic [15:0] countdown_q;
	logic [1:0]  uv_q, heater_q;

	logic        pump_on_d, start_phase_d;
	logic [15:0] countdown_d;
	logic [1:0]  uv_d, heater_d;

	logic                 out_valid_q, skid_valid_q;
	ppc_pkg::out_item_t   out_q, skid_q, result;

	logic in_xfer, out_xfer;
	logic flow_ok, hour_active;
	logic signed [12:0] temp_ext, band_hi, band_lo, center;

	assign in_stall  = skid_valid_q;
	assign in_xfer   = in_valid && !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_xfer  = out_valid_q && !out_stall;
	assign out_data  = out_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= ppc_pkg::MODE_STOP;
			setpoint_q      <= ppc_pkg::SETPOINT_RST;
			hysteresis_q    <= ppc_pkg::HYSTERESIS_RST;
			flow_thresh_q   <= ppc_pkg::FLOW_THRESH_RST;
			hour_mask_q     <= ppc_pkg::HOUR_MASK_RST;
			startup_speed_q <= ppc_pkg::STARTUP_SPEED_RST;
			startup_ticks_q <= ppc_pkg::STARTUP_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ppc_pkg::REG_MODE:          mode_q <= ppc_pkg::mode_t'(cfg_data[1:0]);
				ppc_pkg::REG_SETPOINT:      setpoint_q <= cfg_data[5:0];
				ppc_pkg::REG_HYSTERESIS:    hysteresis_q <= cfg_data[7:0];
				ppc_pkg::REG_FLOW_THRESH:   flow_thresh_q <= cfg_data[15:0];
				ppc_pkg::REG_HOUR_MASK:     hour_mask_q <= cfg_data[23:0];
				ppc_pkg::REG_STARTUP_SPEED: startup_speed_q <= cfg_data[9:0];
				ppc_pkg::REG_STARTUP_TICKS: startup_ticks_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign flow_ok     = in_data.flow_lph > flow_thresh_q;
	assign hour_active = (in_data.hour < 5'(ppc_pkg::HOURS)) && hour_mask_q[in_data.hour];
	assign temp_ext    = 13'(in_data.temperature);
	assign center      = $signed({3'b000, setpoint_q, 4'b0000});
	assign band_hi     = center + $signed({5'b00000, hysteresis_q});
	assign band_lo     = center - $signed({5'b00000, hysteresis_q});

	// Next device state for one item.
	always_comb begin
		logic run_heat, request;
		logic [15:0] count_dec;
		pump_on_d     = pump_on_q;
		start_phase_d = start_phase_q;
		countdown_d   = countdown_q;
		uv_d          = uv_q;
		heater_d      = heater_q;
		run_heat      = 1'b0;
		request       = 1'b0;
		count_dec     = (countdown_q != 16'd0) ? countdown_q - 16'd1 : 16'd0;
		if (in_data.command == ppc_pkg::CMD_EVALUATE) begin
			unique case (mode_q)
				ppc_pkg::MODE_STOP: begin
					pump_on_d     = 1'b0;
					start_phase_d = 1'b0;
					countdown_d   = 16'd0;
					uv_d          = ppc_pkg::DEV_OFF;
					heater_d      = ppc_pkg::DEV_OFF;
				end
				ppc_pkg::MODE_FILTER: begin
					request  = 1'b1;
					heater_d = ppc_pkg::DEV_OFF;
					uv_d     = flow_ok ? ppc_pkg::DEV_ON : ppc_pkg::DEV_LOW_FLOW;
				end
				ppc_pkg::MODE_SCHEDULED: begin
					if (hour_active) begin
						run_heat = 1'b1;
					end else begin
						pump_on_d     = 1'b0;
						start_phase_d = 1'b0;
						countdown_d   = 16'd0;
						uv_d          = ppc_pkg::DEV_OFF;
						heater_d      = ppc_pkg::DEV_OFF;
					end
				end
				ppc_pkg::MODE_HEAT: run_heat = 1'b1;
				default: ;
			endcase
			if (run_heat) begin
				request = 1'b1;
				if (flow_ok) begin
					uv_d = ppc_pkg::DEV_ON;
					if (heater_q == ppc_pkg::DEV_ON) begin
						if (temp_ext >= band_hi) heater_d = ppc_pkg::DEV_OFF;
					end else if (temp_ext <= band_lo) begin
						heater_d = ppc_pkg::DEV_ON;
					end
				end else begin
					uv_d     = ppc_pkg::DEV_LOW_FLOW;
					heater_d = ppc_pkg::DEV_LOW_FLOW;
				end
			end
			// A requested idle pump starts up, or runs at once if no startup ticks.
			if (request && !pump_on_q && !start_phase_q) begin
				if (startup_ticks_q == 16'd0) begin
					pump_on_d = 1'b1;
				end else begin
					start_phase_d = 1'b1;
					countdown_d   = startup_ticks_q;
				end
			end
		end else if (start_phase_q) begin
			countdown_d = count_dec;
			if (count_dec == 16'd0) begin
				start_phase_d = 1'b0;
				pump_on_d     = 1'b1;
			end
		end
	end

	always_comb begin
		result.pump_status   = pump_on_d;
		result.pump_starting = start_phase_d;
		result.pump_enable   = pump_on_d | start_phase_d;
		result.pump_pwm      = start_phase_d ? startup_speed_q[9:2] : in_data.speed_setting[9:2];
		result.uv_status     = uv_d;
		result.heater_status = heater_d;
		result.uv_drive      = (uv_d == ppc_pkg::DEV_ON);
		result.heater_drive  = (heater_d == ppc_pkg::DEV_ON);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pump_on_q     <= 1'b0;
			start_phase_q <= 1'b0;
			countdown_q   <= 16'd0;
			uv_q          <= ppc_pkg::DEV_OFF;
			heater_q      <= ppc_pkg::DEV_OFF;
		end else if (in_xfer) begin
			pump_on_q     <= pump_on_d;
			start_phase_q <= start_phase_d;
			countdown_q   <= countdown_d;
			uv_q          <= uv_d;
			heater_q      <= heater_d;
		end
	end

	// Output register with one skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (out_xfer) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end
			end else if (in_xfer) begin
				if (out_valid_q && !out_xfer) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_xfer) out_q <= skid_q;
		end else if (in_xfer) begin
			if (out_valid_q && !out_xfer) begin
				skid_q <= result;
			end else begin
				out_q <= result;
			end
		end
	end

	// The skid entry only fills behind a waiting result.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid without output entry");

	a_pump_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(pump_on_q && start_phase_q))
		else $error("pump running and starting at once");

	a_start_count: assert property (@(posedge clk) disable iff (!arst_n)
		start_phase_q |-> (countdown_q != 16'd0))
		else $error("startup phase with empty countdown");

	a_drive_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.heater_drive == (out_q.heater_status == ppc_pkg::DEV_ON))
			&& (out_q.pump_enable == (out_q.pump_status || out_q.pump_starting)))
		else $error("relay drive disagrees with status");

	a_tick_keeps_devices: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && in_data.command == ppc_pkg::CMD_TICK) |=>
			(uv_q == $past(uv_q)) && (heater_q == $past(heater_q)))
		else $error("tick changed UV or heater state");

endmodule
`default_nettype wire
